// ===== rtl/scs_pkg.sv =====
// ----------------------------------------------------------------------------
// scs_pkg - shared types and constants of the strongest channel scanner
// Field widths, word layouts, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package scs_pkg;

	localparam int CH_W        = 6;   // channel index
	localparam int LVL_W       = 9;   // signed dBm level
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_W       = 9;   // widest register
	localparam int IN_TDATA_W  = 16;  // signal_level padded to bytes
	localparam int OUT_TDATA_W = 24;  // three channel fields padded to bytes
	localparam int OUT_TUSER_W = 2;   // hit, found

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_CH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_CH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

	// register reset values
	localparam logic [CH_W-1:0]         FIRST_CH_RST  = 6'd0;
	localparam logic [CH_W-1:0]         LAST_CH_RST   = 6'd63;
	localparam logic signed [LVL_W-1:0] THRESHOLD_RST = -9'sd65;

	typedef enum logic [1:0] {
		ST_IDLE,  // ready for a reading
		ST_SCAN,  // walking the hit store for the strongest entry
		ST_EMIT   // result waits for the output register
	} state_t;

endpackage

// ===== rtl/strongest_channel_scanner.sv =====
// ----------------------------------------------------------------------------
// strongest_channel_scanner - sweep scanner that picks the strongest hit
// Takes one level reading per tuned channel, collects hits above threshold
// and reports the earliest strongest of HITS_NEEDED hits.
// ----------------------------------------------------------------------------
// Usage:
//  - s_* channel: one word per reading, signal_level (signed dBm) in
//    s_tdata[8:0]. Taken when s_tvalid and s_tready are both high.
//  - m_* channel: one result word per reading. m_tdata holds
//    measured_channel, best_channel, next_channel; m_tuser holds hit, found.
//  - cfg_*: write-only registers, index 0 first_channel, 1 last_channel,
//    2 level_threshold; index 3 is ignored. Write only while idle.
//  - Steps per reading: accept, then load output when no find happens;
//    when the hit store is full, a scan of the store comes between; the strongest entry is
//    found by one comparator stepping through the store one entry a cycle.
//  - s_tready is high only in the idle state. A result that sits in the
//    output register does not block the next reading; that reading then
//    waits in ST_EMIT until the receiver takes the previous word.
//  - Reset: registers return to their defaults, scan position to channel
//    0, hit count to zero. The hit store is not cleared; every entry is
//    written before the scan reads it.
// ----------------------------------------------------------------------------
module strongest_channel_scanner #(
	parameter int HITS_NEEDED   = 5,
	parameter int CHANNEL_COUNT = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_we,
	input  logic [scs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [scs_pkg::CFG_W-1:0]       cfg_data,
	// reading input
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [scs_pkg::IN_TDATA_W-1:0]  s_tdata,   // [8:0] signal_level
	// result output
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [5:0] measured_channel, [11:6] best_channel, [17:12] next_channel
	output logic [scs_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic [scs_pkg::OUT_TUSER_W-1:0] m_tuser    // [0] hit, [1] found
);
	import scs_pkg::*;

	localparam int CNT_W  = $clog2(HITS_NEEDED + 1);
	localparam int IDX_W  = (HITS_NEEDED > 1) ? $clog2(HITS_NEEDED) : 1;
	// highest usable channel; channel fields are 6 bits wide regardless
	localparam int CH_MAX = (CHANNEL_COUNT - 1 > 63) ? 63 : CHANNEL_COUNT - 1;

	// configuration registers
	logic [CH_W-1:0]         first_q, last_q;
	logic signed [LVL_W-1:0] thr_q;

	// scan state
	logic [CH_W-1:0]  pos_q;
	logic [CNT_W-1:0] cnt_q;

	// hit store
	logic [CH_W-1:0]         ch_mem  [HITS_NEEDED];
	logic signed [LVL_W-1:0] lvl_mem [HITS_NEEDED];

	// per-reading work registers
	logic [CH_W-1:0]         meas_q, best_ch_q, next_q;
	logic                    hit_q, found_q;
	logic signed [LVL_W-1:0] best_lvl_q;
	logic [IDX_W-1:0]        idx_q;

	state_t state_q, state_d;

	// output register
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic [OUT_TUSER_W-1:0] m_tuser_q;

	// ------------------------------------------------------------------
	// Reading evaluation, used at the accept edge
	// ------------------------------------------------------------------
	logic [CH_W-1:0]         lo, hi, pos_eff, pos_new;
	logic [CH_W:0]           pos_inc;
	logic signed [LVL_W-1:0] level;
	logic                    is_hit, found_now, wrap;
	logic [CNT_W-1:0]        cnt_new;

	always_comb begin
		lo      = (first_q > CH_W'(CH_MAX)) ? CH_W'(CH_MAX) : first_q;
		hi      = (last_q  > CH_W'(CH_MAX)) ? CH_W'(CH_MAX) : last_q;
		// out of range (also empty range) restarts at the first channel
		pos_eff = (pos_q < lo || pos_q > hi) ? lo : pos_q;
		level   = s_tdata[LVL_W-1:0];
		is_hit  = level > thr_q;
		// the store never stays full: a find clears the count
		found_now = is_hit && (cnt_q == CNT_W'(HITS_NEEDED - 1));
		pos_inc = {1'b0, pos_eff} + {{CH_W{1'b0}}, 1'b1};
		wrap    = pos_inc > {1'b0, hi};
		if (found_now) begin
			pos_new = pos_eff;
			cnt_new = '0;
		end else if (wrap) begin
			pos_new = lo;
			cnt_new = '0;
		end else begin
			pos_new = pos_inc[CH_W-1:0];
			cnt_new = cnt_q + CNT_W'(is_hit);
		end
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	logic accept, scan_last, out_free, load_out, take_entry;
	logic signed [LVL_W-1:0] rd_lvl;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign rd_lvl   = lvl_mem[idx_q];
	assign scan_last = (idx_q == IDX_W'(HITS_NEEDED - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = found_now ? ST_SCAN : ST_EMIT;
			ST_SCAN: if (scan_last) state_d = ST_EMIT;
			ST_EMIT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		load_out   = 1'b0;
		take_entry = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			// entry 0 seeds the best; later entries win only when strictly
			// stronger, so the earliest of equal levels stays
			ST_SCAN: take_entry = (idx_q == '0) || (rd_lvl > best_lvl_q);
			ST_EMIT: load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes; unknown index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= FIRST_CH_RST;
			last_q  <= LAST_CH_RST;
			thr_q   <= THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FIRST_CH:  first_q <= cfg_data[CH_W-1:0];
				REG_LAST_CH:   last_q  <= cfg_data[CH_W-1:0];
				REG_THRESHOLD: thr_q   <= cfg_data[LVL_W-1:0];
				default: ;
			endcase
		end
	end

	// scan position and hit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= FIRST_CH_RST;
			cnt_q <= '0;
		end else if (accept) begin
			pos_q <= pos_new;
			cnt_q <= cnt_new;
		end
	end

	// hit store, written at the current count
	always_ff @(posedge clk) begin
		if (accept && is_hit) begin
			ch_mem[cnt_q[IDX_W-1:0]]  <= pos_eff;
			lvl_mem[cnt_q[IDX_W-1:0]] <= level;
		end
	end

	// work registers
	always_ff @(posedge clk) begin
		if (accept) begin
			meas_q    <= pos_eff;
			hit_q     <= is_hit;
			found_q   <= found_now;
			best_ch_q <= '0;
			next_q    <= pos_new;
			idx_q     <= '0;
		end else if (state_q == ST_SCAN) begin
			if (take_entry) begin
				best_ch_q  <= ch_mem[idx_q];
				best_lvl_q <= rd_lvl;
			end
			if (!scan_last) idx_q <= idx_q + IDX_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= {{(OUT_TDATA_W - 3 * CH_W){1'b0}}, next_q, best_ch_q, meas_q};
			m_tuser_q <= {found_q, hit_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== rtl/scs_checker.sv =====
// ----------------------------------------------------------------------------
// scs_checker - port-level checks of the strongest channel scanner
// Watches the result and input channels of the top level over time.
// ----------------------------------------------------------------------------
module scs_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [scs_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic [scs_pkg::OUT_TUSER_W-1:0] m_tuser
);
	import scs_pkg::*;

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// a find only comes from a hit
	a_found_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0])
		else $error("found without hit");

	// best channel reads zero unless a find is reported
	a_best_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> m_tdata[2*CH_W-1:CH_W] == '0)
		else $error("best channel set without find");

	// one reading at a time: ready drops right after a take
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second reading taken back to back");

endmodule

bind strongest_channel_scanner scs_checker u_scs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
